@@ design/sfir_pkg.sv @@
package sfir_pkg;

  // Default tap count
  localparam int TAPS_DEF = 64;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 5;

  // Highest coefficient slot count reachable through the index field
  localparam int CIDX_SLOTS = 1 << CIDX_W;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // Address width for a memory of the given depth, at least one bit
  function automatic int addr_w(input int depth);
    addr_w = (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

@@ design/sfir_ram.sv @@
module sfir_ram
  import sfir_pkg::*;
#(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [addr_w(DEPTH)-1:0]  waddr,
  input  logic [WIDTH-1:0]          wdata,
  input  logic [addr_w(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ design/symmetric_fir_filter.sv @@
// Linear-phase FIR filter with symmetric Q1.15 coefficients. An input transfer either
// writes one coefficient (kind 1, no result) or delivers one audio sample (kind 0, one
// result). Samples go into a circular delay line held in two copies of a memory, so each
// cycle one mirrored pair (newest with oldest, working inward) is read, pre-added and
// multiplied by its coefficient from a coefficient memory; odd tap counts add the middle
// tap alone. The sum is floored by 2^15 and saturated to 16 bits, with a flag. Each pair
// passes the issue, pre-add, multiply and accumulate stages; the sum is registered as a
// result once the pipeline drains, and a coefficient is written on its transfer. One sample is
// in work at a time; a finished result waits in the output register while the next item
// is taken. Only slots below min(32, (TAPS+1)/2) are writable; coefficients beyond them
// read as zero. Delay line and coefficients read as zero after reset until written.
module symmetric_fir_filter
  import sfir_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  input  logic [CIDX_W-1:0]          in_coef_index,
  input  logic signed [COEF_W-1:0]   in_coef_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_filtered_sample,
  output logic                       out_saturated
);

  localparam int NS       = (TAPS + 1) / 2;
  localparam int CSTORE   = (NS < CIDX_SLOTS) ? NS : CIDX_SLOTS;
  localparam int DAW      = addr_w(TAPS);
  localparam int CAW      = addr_w(CSTORE);
  localparam int SW       = addr_w(NS);
  localparam int PAIR_W   = SAMPLE_W + 1;
  localparam int PROD_W   = PAIR_W + COEF_W;
  localparam int ACC_W    = PROD_W + SW + 1;
  localparam int Q_W      = ACC_W - 15;
  localparam bit ODD      = (TAPS % 2) != 0;

  localparam logic signed [Q_W-1:0] QMAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] QMIN = -Q_W'(32768);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [DAW-1:0]  wp_r, wp_nxt;
  logic            filled_r, filled_nxt;
  logic [DAW-1:0]  ra_r, ra_nxt;
  logic [DAW-1:0]  rb_r, rb_nxt;
  logic [SW-1:0]   step_r, step_nxt;
  logic [CSTORE-1:0] cvld_r;

  // Read pipeline tags
  logic rd_vld_r, rd_va_r, rd_vb_r, rd_vc_r;
  logic pv_r, mv_r;

  logic signed [PAIR_W-1:0] pair_r;
  logic signed [COEF_W-1:0] coef_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;

  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] out_sample_r;
  logic                       out_sat_r;

  logic in_xfer, smp_xfer, coef_xfer, issue, last_step, is_mid, fin_go, pipe_busy;
  logic coef_wr;
  logic [SAMPLE_W-1:0] da_rdata, db_rdata;
  logic [COEF_W-1:0]   c_rdata;
  logic signed [Q_W-1:0] q;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign smp_xfer  = in_xfer && (in_kind == KIND_SAMPLE);
  assign coef_xfer = in_xfer && (in_kind == KIND_COEF);
  assign coef_wr   = coef_xfer && (32'(in_coef_index) < NS);

  assign issue     = (state_r == S_RUN);
  assign last_step = (step_r == SW'(NS - 1));
  assign is_mid    = ODD && last_step;
  assign pipe_busy = rd_vld_r || pv_r || mv_r;
  assign fin_go    = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // Delay line, two copies for the two ends of each pair
  sfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_dly_a (
    .clk   (clk),
    .we    (smp_xfer),
    .waddr (wp_r),
    .wdata (in_sample_in),
    .raddr (ra_r),
    .rdata (da_rdata)
  );

  sfir_ram #(.WIDTH(SAMPLE_W), .DEPTH(TAPS)) u_dly_b (
    .clk   (clk),
    .we    (smp_xfer),
    .waddr (wp_r),
    .wdata (in_sample_in),
    .raddr (rb_r),
    .rdata (db_rdata)
  );

  // Coefficient memory
  sfir_ram #(.WIDTH(COEF_W), .DEPTH(CSTORE)) u_coef (
    .clk   (clk),
    .we    (coef_wr),
    .waddr (CAW'(in_coef_index)),
    .wdata (in_coef_value),
    .raddr (CAW'(step_r)),
    .rdata (c_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    filled_nxt = filled_r;
    ra_nxt     = ra_r;
    rb_nxt     = rb_r;
    step_nxt   = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (smp_xfer) begin
          state_nxt = S_RUN;
          ra_nxt    = wp_r;
          rb_nxt    = (wp_r == DAW'(TAPS - 1)) ? '0 : wp_r + 1'b1;
          step_nxt  = '0;
        end
      end
      S_RUN: begin
        ra_nxt   = (ra_r == '0) ? DAW'(TAPS - 1) : ra_r - 1'b1;
        rb_nxt   = (rb_r == DAW'(TAPS - 1)) ? '0 : rb_r + 1'b1;
        step_nxt = step_r + 1'b1;
        if (last_step) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
          if (wp_r == DAW'(TAPS - 1)) begin
            wp_nxt     = '0;
            filled_nxt = 1'b1;
          end else begin
            wp_nxt = wp_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wp_r     <= '0;
      filled_r <= 1'b0;
      cvld_r   <= '0;
      rd_vld_r <= 1'b0;
      pv_r     <= 1'b0;
      mv_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wp_r     <= wp_nxt;
      filled_r <= filled_nxt;
      if (coef_wr) begin
        cvld_r[CAW'(in_coef_index)] <= 1'b1;
      end
      rd_vld_r <= issue;
      pv_r     <= rd_vld_r;
      mv_r     <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
    step_r <= step_nxt;
  end

  // Issue stage: entry validity, middle tap drops the mirrored read
  always_ff @(posedge clk) begin
    rd_va_r <= filled_r || (ra_r <= wp_r);
    rd_vb_r <= (filled_r || (rb_r <= wp_r)) && !is_mid;
    rd_vc_r <= (32'(step_r) < CSTORE) && cvld_r[CAW'(step_r)];
  end

  // Pre-add stage
  always_ff @(posedge clk) begin
    pair_r <= (rd_va_r ? PAIR_W'($signed(da_rdata)) : '0)
            + (rd_vb_r ? PAIR_W'($signed(db_rdata)) : '0);
    coef_r <= rd_vc_r ? $signed(c_rdata) : '0;
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(pair_r) * PROD_W'(coef_r);
  end

  // Accumulate
  always_ff @(posedge clk) begin
    if (smp_xfer) begin
      acc_r <= '0;
    end else if (mv_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // Floor by 2^15 (drop the low bits), then saturate
  assign q = acc_r[ACC_W-1:15];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      priority if (q > QMAX) begin
        out_sample_r <= SAMPLE_W'(QMAX);
        out_sat_r    <= 1'b1;
      end else if (q < QMIN) begin
        out_sample_r <= SAMPLE_W'(QMIN);
        out_sat_r    <= 1'b1;
      end else begin
        out_sample_r <= SAMPLE_W'(q);
        out_sat_r    <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;
  assign out_saturated       = out_sat_r;

endmodule
